>>> rtl/clfl_pkg.sv
// Package: constants, codes and request/result types of the flash log manager.
`default_nettype none
package clfl_pkg;

  localparam int SECTOR_BYTES     = 4096;
  localparam int ENTRY_BYTES      = 64;
  localparam int SECTOR_COUNT     = 4096;
  localparam int FIRST_LOG_SECTOR = 1;
  localparam int ENTRY_LIMIT      = 262080;
  localparam int PAYLOAD_MAX      = 56;

  localparam int ENTRIES_PER_SECTOR = SECTOR_BYTES / ENTRY_BYTES;
  localparam int LOG_BASE           = FIRST_LOG_SECTOR * SECTOR_BYTES;
  localparam int LOG_AREA           = (SECTOR_COUNT - 1) * SECTOR_BYTES;

  localparam int SLOT_W = 18;
  localparam int ADDR_W = 24;

  // request function codes
  localparam logic [2:0] FN_WRITE   = 3'd0;
  localparam logic [2:0] FN_READ    = 3'd1;
  localparam logic [2:0] FN_TICK    = 3'd2;
  localparam logic [2:0] FN_CLEAR   = 3'd3;
  localparam logic [2:0] FN_RESTORE = 3'd4;

  // flash operation codes
  localparam logic [2:0] OP_ERASE   = 3'd0;
  localparam logic [2:0] OP_PROGRAM = 3'd1;
  localparam logic [2:0] OP_SAVE    = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_REJECT  = 3'd4;

  // configuration register indexes
  localparam logic REG_FLASH_PRESENT = 1'b0;

  typedef struct packed {
    logic [2:0]        func;
    logic [7:0]        entry_type;
    logic [7:0]        data_len;
    logic [31:0]       read_index;
    logic [31:0]       tick_ms;
    logic              stored_valid;
    logic [SLOT_W-1:0] stored_write_index;
    logic [31:0]       stored_count;
    logic [31:0]       stored_boots;
  } req_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [ADDR_W-1:0] flash_addr;
    logic [31:0]       stamp;
    logic [7:0]        out_type;
    logic [5:0]        out_len;
    logic [SLOT_W-1:0] saved_index;
    logic [31:0]       saved_count;
    logic [31:0]       saved_boots;
    logic [SLOT_W-1:0] visible_count;
    logic              last;
  } rsp_t;

  // datapath -> controller
  typedef struct packed {
    logic       is_tick;
    logic       is_write;
    logic       need_erase;
    logic       need_save;
    logic [2:0] single_op;
  } dp_stat_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       emit;
    logic [2:0] op;
    logic       last;
  } ctl_cmd_t;

endpackage
`default_nettype wire

>>> rtl/circular_flash_log_manager_unit.sv
// Top level: circular flash log manager with APB configuration port.
// The first result appears in the cycle after the request is accepted; results follow
// back to back. Write: 1 to 3 results; read, clear, restore and rejects: 1; ticks: none.
// A new request is taken only once the results of the last one are out; ticks can be
// taken one per cycle. The controller steps one flash op a cycle.
// Reset clears the log state and flash_present; no clearing pass is needed.
// Results are strobed for one cycle and cannot be stalled by the receiver.
`default_nettype none
module circular_flash_log_manager_unit import clfl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req_i,
  output logic             result_valid_o,
  output rsp_t             result_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic     flash_present_q;
  logic     reg_sel;
  dp_stat_t stat;
  ctl_cmd_t cmd;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_FLASH_PRESENT);
  assign prdata  = reg_sel ? {31'd0, flash_present_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_present_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      flash_present_q <= pwdata[0];
    end
  end

  clfl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  clfl_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .flash_present_i(flash_present_q),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .rsp_o          (result_o)
  );

  assign result_valid_o = cmd.emit;

endmodule
`default_nettype wire

>>> rtl/clfl_ctrl.sv
// Controller: sequences the flash operations that each request emits.
`default_nettype none
module clfl_ctrl import clfl_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire dp_stat_t stat_i,
  output logic          busy_o,
  output ctl_cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ERASE = 3'd1;
  localparam logic [2:0] ST_PROG  = 3'd2;
  localparam logic [2:0] ST_SAVE  = 3'd3;
  localparam logic [2:0] ST_ONE   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       save_q, save_d;
  logic [2:0] op_q, op_d;
  logic       accept;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    save_d  = save_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          save_d = stat_i.need_save;
          op_d   = stat_i.single_op;
          if (stat_i.is_tick) begin
            state_d = ST_IDLE;
          end else if (stat_i.is_write) begin
            state_d = stat_i.need_erase ? ST_ERASE : ST_PROG;
          end else begin
            state_d = ST_ONE;
          end
        end
      end
      ST_ERASE: state_d = ST_PROG;
      ST_PROG:  state_d = save_q ? ST_SAVE : ST_IDLE;
      ST_SAVE:  state_d = ST_IDLE;
      ST_ONE:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load = accept;
    cmd_o.emit = busy_o;
    cmd_o.op   = OP_REJECT;
    cmd_o.last = 1'b0;
    unique case (state_q)
      ST_ERASE: cmd_o.op = OP_ERASE;
      ST_PROG: begin
        cmd_o.op   = OP_PROGRAM;
        cmd_o.last = !save_q;
      end
      ST_SAVE: begin
        cmd_o.op   = OP_SAVE;
        cmd_o.last = 1'b1;
      end
      ST_ONE: begin
        cmd_o.op   = op_q;
        cmd_o.last = 1'b1;
      end
      default: cmd_o.op = OP_REJECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      save_q  <= 1'b0;
      op_q    <= OP_REJECT;
    end else begin
      state_q <= state_d;
      save_q  <= save_d;
      op_q    <= op_d;
    end
  end

  // an erase is always followed by its program
  a_erase_then_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ERASE |=> state_q == ST_PROG)
    else $error("erase not followed by program");

  // the final result of a request frees the block
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.last |=> state_q == ST_IDLE)
    else $error("block still busy after final result");

  // a tick produces no result
  a_tick_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && stat_i.is_tick |=> !cmd_o.emit)
    else $error("tick produced a result");

endmodule
`default_nettype wire

>>> rtl/clfl_datapath.sv
// Datapath: log state registers, address arithmetic and result formatting.
`default_nettype none
module clfl_datapath import clfl_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     flash_present_i,
  input  wire req_t     req_i,
  input  wire ctl_cmd_t cmd_i,
  output dp_stat_t      stat_o,
  output rsp_t          rsp_o
);

  localparam logic [ADDR_W-1:0] BaseA   = ADDR_W'(LOG_BASE);
  localparam logic [ADDR_W-1:0] AreaA   = ADDR_W'(LOG_AREA);
  localparam logic [ADDR_W-1:0] EntryA  = ADDR_W'(ENTRY_BYTES);
  localparam logic [ADDR_W-1:0] SecMask = ADDR_W'(SECTOR_BYTES - 1);
  localparam logic [SLOT_W-1:0] LimitS  = SLOT_W'(ENTRY_LIMIT);
  localparam logic [31:0]       Limit32 = 32'(ENTRY_LIMIT);
  localparam logic [31:0]       EpsMask = 32'(ENTRIES_PER_SECTOR - 1);
  localparam logic [7:0]        LenMax  = 8'(PAYLOAD_MAX);

  logic [SLOT_W-1:0] next_slot_q;
  logic [31:0]       total_q, boots_q, time_q;
  logic [ADDR_W-1:0] addr_q;
  logic [31:0]       stamp_q;
  logic [7:0]        type_q;
  logic [5:0]        len_q;

  logic              wrapped;
  logic [SLOT_W-1:0] visible;
  logic              fn_ok;
  logic [ADDR_W-1:0] off_raw, off, wr_addr;
  logic [SLOT_W-1:0] slot_inc, slot_wr;
  logic [31:0]       total_inc;
  logic              rd_ok;
  logic [SLOT_W:0]   rd_sum;
  logic [SLOT_W-1:0] rd_wrap, rd_slot;
  logic [ADDR_W-1:0] rd_addr;
  logic [5:0]        len_clamp;
  logic [SLOT_W-1:0] restore_slot;

  assign wrapped = total_q > Limit32;
  assign visible = wrapped ? LimitS : total_q[SLOT_W-1:0];
  assign fn_ok   = flash_present_i &&
                   (req_i.func == FN_WRITE || req_i.func == FN_READ ||
                    req_i.func == FN_CLEAR || req_i.func == FN_RESTORE);

  // write address: slot offset folded into the log area
  assign off_raw   = ADDR_W'(next_slot_q) * EntryA;
  assign off       = (off_raw >= AreaA) ? off_raw - AreaA : off_raw;
  assign wr_addr   = BaseA + off;
  assign slot_inc  = next_slot_q + SLOT_W'(1);
  assign slot_wr   = (slot_inc >= LimitS) ? '0 : slot_inc;
  assign total_inc = total_q + 32'd1;

  // read address: oldest entry sits at next_slot once the ring has wrapped
  assign rd_ok   = req_i.read_index < {{(32-SLOT_W){1'b0}}, visible};
  assign rd_sum  = {1'b0, next_slot_q} + {1'b0, req_i.read_index[SLOT_W-1:0]};
  assign rd_wrap = (rd_sum >= {1'b0, LimitS}) ? SLOT_W'(rd_sum - {1'b0, LimitS})
                                              : rd_sum[SLOT_W-1:0];
  assign rd_slot = wrapped ? rd_wrap : req_i.read_index[SLOT_W-1:0];
  assign rd_addr = BaseA + ADDR_W'(rd_slot) * EntryA;

  assign len_clamp    = (req_i.data_len > LenMax) ? LenMax[5:0] : req_i.data_len[5:0];
  assign restore_slot = (req_i.stored_write_index >= LimitS) ? '0
                                                             : req_i.stored_write_index;

  always_comb begin
    stat_o.is_tick    = (req_i.func == FN_TICK);
    stat_o.is_write   = fn_ok && (req_i.func == FN_WRITE);
    stat_o.need_erase = (off & SecMask) == '0;
    stat_o.need_save  = (total_inc & EpsMask) == '0;
    stat_o.single_op  = OP_REJECT;
    if (fn_ok) begin
      if (req_i.func == FN_READ) begin
        stat_o.single_op = rd_ok ? OP_READ : OP_REJECT;
      end else begin
        stat_o.single_op = OP_SAVE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_slot_q <= '0;
      total_q     <= '0;
      boots_q     <= '0;
      time_q      <= '0;
    end else if (cmd_i.load) begin
      if (req_i.func == FN_TICK) begin
        time_q <= time_q + req_i.tick_ms;
      end else if (fn_ok) begin
        priority if (req_i.func == FN_WRITE) begin
          next_slot_q <= slot_wr;
          total_q     <= total_inc;
        end else if (req_i.func == FN_CLEAR) begin
          next_slot_q <= '0;
          total_q     <= '0;
        end else if (req_i.func == FN_RESTORE) begin
          if (req_i.stored_valid) begin
            next_slot_q <= restore_slot;
            total_q     <= req_i.stored_count;
            boots_q     <= req_i.stored_boots + 32'd1;
          end else begin
            next_slot_q <= '0;
            total_q     <= '0;
            boots_q     <= 32'd1;
          end
        end else begin
          next_slot_q <= next_slot_q;
        end
      end
    end
  end

  // request payload, captured at accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q  <= (req_i.func == FN_READ) ? rd_addr : wr_addr;
      stamp_q <= time_q;
      type_q  <= req_i.entry_type;
      len_q   <= len_clamp;
    end
  end

  always_comb begin
    rsp_o               = '0;
    rsp_o.op            = cmd_i.op;
    rsp_o.visible_count = visible;
    rsp_o.last          = cmd_i.last;
    unique case (cmd_i.op)
      OP_ERASE, OP_READ: rsp_o.flash_addr = addr_q;
      OP_PROGRAM: begin
        rsp_o.flash_addr = addr_q;
        rsp_o.stamp      = stamp_q;
        rsp_o.out_type   = type_q;
        rsp_o.out_len    = len_q;
      end
      OP_SAVE: begin
        rsp_o.saved_index = next_slot_q;
        rsp_o.saved_count = total_q;
        rsp_o.saved_boots = boots_q;
      end
      default: rsp_o.flash_addr = '0;
    endcase
  end

  a_slot_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_slot_q < LimitS)
    else $error("write index outside the ring");

  a_slot_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && stat_o.is_write |=> next_slot_q == $past(slot_wr))
    else $error("write index did not advance");

endmodule
`default_nettype wire

>>> bench/tb_circular_flash_log_manager_unit.sv
`timescale 1ns / 1ps
// Testbench for the flash log manager: directed and random requests checked against a predictor.
module tb_circular_flash_log_manager_unit;
  import clfl_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int MAX_REPORTS = 10;
  localparam logic [2:0] FN_UNUSED_LO = 3'd5;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;
  localparam logic [2:0] FLASH_PRESENT_ADDR = 3'({REG_FLASH_PRESENT, 2'b00});

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_in;
  logic        result_valid;
  rsp_t        result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predicted block state
  logic              flash_on;
  logic [SLOT_W-1:0] slot_ptr;
  logic [31:0]       entry_total;
  logic [31:0]       boot_cnt;
  logic [31:0]       ms_clock;

  rsp_t expected_ops[$];
  rsp_t want_op;
  int   mismatches = 0;
  int   cycles = 0;
  bit   no_idle;

  circular_flash_log_manager_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_in),
    .result_valid_o (result_valid),
    .result_o       (result),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] visible_entries();
    return (entry_total > 32'(ENTRY_LIMIT)) ? 32'(ENTRY_LIMIT) : entry_total;
  endfunction

  // Flash operations that one accepted request causes; updates the predicted state.
  function automatic void predict_flash_ops(req_t rq);
    rsp_t        ops[$];
    rsp_t        r;
    logic [63:0] off;
    logic [63:0] slot;
    logic [7:0]  len;
    if (rq.func == FN_TICK) begin
      ms_clock += rq.tick_ms;
      return;
    end
    r = '0;
    if (rq.func > FN_RESTORE || !flash_on) begin
      r.op = OP_REJECT;
      ops.push_back(r);
    end else if (rq.func == FN_WRITE) begin
      off = (64'(slot_ptr) * ENTRY_BYTES) % LOG_AREA;
      r.flash_addr = ADDR_W'(LOG_BASE + off);
      // entering a fresh sector erases it first
      if (off % SECTOR_BYTES == 0) begin
        r.op = OP_ERASE;
        ops.push_back(r);
      end
      len = (rq.data_len > PAYLOAD_MAX) ? 8'(PAYLOAD_MAX) : rq.data_len;
      r.op = OP_PROGRAM;
      r.stamp = ms_clock;
      r.out_type = rq.entry_type;
      r.out_len = len[5:0];
      ops.push_back(r);
      slot_ptr = (32'(slot_ptr) + 1 >= ENTRY_LIMIT) ? '0 : slot_ptr + 1'b1;
      entry_total += 1;
      if (entry_total % ENTRIES_PER_SECTOR == 0) begin
        r = '0;
        r.op = OP_SAVE;
        r.saved_index = slot_ptr;
        r.saved_count = entry_total;
        r.saved_boots = boot_cnt;
        ops.push_back(r);
      end
    end else if (rq.func == FN_READ) begin
      if (rq.read_index >= visible_entries()) begin
        r.op = OP_REJECT;
      end else begin
        // once wrapped, the oldest entry sits at the write pointer
        slot = (entry_total > 32'(ENTRY_LIMIT)) ?
               (64'(slot_ptr) + 64'(rq.read_index)) % ENTRY_LIMIT : 64'(rq.read_index);
        r.op = OP_READ;
        r.flash_addr = ADDR_W'(LOG_BASE + slot * ENTRY_BYTES);
      end
      ops.push_back(r);
    end else begin
      if (rq.func == FN_CLEAR) begin
        slot_ptr = '0;
        entry_total = '0;
      end else if (rq.stored_valid) begin
        slot_ptr = (32'(rq.stored_write_index) >= ENTRY_LIMIT) ? '0 : rq.stored_write_index;
        entry_total = rq.stored_count;
        boot_cnt = rq.stored_boots + 1;
      end else begin
        slot_ptr = '0;
        entry_total = '0;
        boot_cnt = 32'd1;
      end
      r.op = OP_SAVE;
      r.saved_index = slot_ptr;
      r.saved_count = entry_total;
      r.saved_boots = boot_cnt;
      ops.push_back(r);
    end
    foreach (ops[k]) begin
      ops[k].visible_count = SLOT_W'(visible_entries());
      ops[k].last = (k == ops.size() - 1);
      expected_ops.push_back(ops[k]);
    end
  endfunction

  // every field random, so unused fields see all bit values too
  function automatic req_t random_req(logic [2:0] fn);
    logic [191:0] raw;
    req_t         rq;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    rq = raw[$bits(req_t)-1:0];
    rq.func = fn;
    return rq;
  endfunction

  task automatic report_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h got %0h", $time, fname, want, got);
    end
  endtask

  task automatic send_request(req_t rq);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    req_in = rq;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    predict_flash_ops(rq);
  endtask

  // drop start and let every outstanding result come out
  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_ops.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_flash_present(logic value);
    settle();
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = FLASH_PRESENT_ADDR;
    pwdata = {31'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    do begin
      @(posedge clk_i);
    end while (pready !== 1'b1);
    flash_on = value;
    // read back
    @(negedge clk_i);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do begin
      @(posedge clk_i);
    end while (pready !== 1'b1);
    report_field("flash_present readback", 32'(flash_on), 32'(prdata[0]));
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic test_flash_absent();
    send_request(random_req(FN_WRITE));
    send_request(random_req(FN_READ));
    send_request(random_req(FN_CLEAR));
    send_request(random_req(FN_RESTORE));
    send_request(random_req(FN_TICK));
    send_request(random_req(FN_UNUSED_HI));
  endtask

  task automatic test_log_writes();
    int   lens[4] = '{0, PAYLOAD_MAX, PAYLOAD_MAX + 1, 255};
    req_t rq;
    foreach (lens[k]) begin
      rq = random_req(FN_WRITE);
      rq.data_len = 8'(lens[k]);
      rq.entry_type = (k % 2) ? 8'hFF : 8'h00;
      send_request(rq);
    end
  endtask

  task automatic test_log_reads();
    logic [31:0] idx[4];
    req_t        rq;
    idx = '{0, visible_entries() - 1, visible_entries(), 32'hFFFF_FFFF};
    foreach (idx[k]) begin
      rq = random_req(FN_READ);
      rq.read_index = idx[k];
      send_request(rq);
    end
  endtask

  task automatic test_restore_cases();
    req_t rq;
    rq = random_req(FN_RESTORE);
    rq.stored_valid = 1'b0;
    send_request(rq);
    // stored index past the ring restarts at zero
    rq = random_req(FN_RESTORE);
    rq.stored_valid = 1'b1;
    rq.stored_write_index = '1;
    send_request(rq);
    // last slot and saturated counters: the restore wraps the boot count, the next write the slot and entry count
    rq = random_req(FN_RESTORE);
    rq.stored_valid = 1'b1;
    rq.stored_write_index = SLOT_W'(ENTRY_LIMIT - 1);
    rq.stored_count = 32'hFFFF_FFFF;
    rq.stored_boots = 32'hFFFF_FFFF;
    send_request(rq);
    rq = random_req(FN_TICK);
    rq.tick_ms = 32'hFFFF_FFFF;
    send_request(rq);
    send_request(random_req(FN_TICK));
    send_request(random_req(FN_WRITE));
  endtask

  task automatic test_wrapped_log();
    logic [31:0] idx[3];
    req_t        rq;
    rq = random_req(FN_RESTORE);
    rq.stored_valid = 1'b1;
    rq.stored_write_index = SLOT_W'(100);
    rq.stored_count = ENTRY_LIMIT + 5;
    send_request(rq);
    idx = '{0, ENTRY_LIMIT - 1, ENTRY_LIMIT};
    foreach (idx[k]) begin
      rq = random_req(FN_READ);
      rq.read_index = idx[k];
      send_request(rq);
    end
  endtask

  task automatic test_clear();
    req_t rq;
    send_request(random_req(FN_CLEAR));
    rq = random_req(FN_READ);
    rq.read_index = '0;
    send_request(rq);
    send_request(random_req(FN_UNUSED_LO));
  endtask

  function automatic req_t random_item();
    int          pick;
    logic [31:0] vis;
    req_t        rq;
    pick = $urandom_range(0, 99);
    vis = visible_entries();
    if (pick < 45) begin
      rq = random_req(FN_WRITE);
    end else if (pick < 70) begin
      rq = random_req(FN_READ);
      if (vis != 0 && $urandom_range(0, 3) != 0)
        rq.read_index = $urandom_range(0, vis - 1);
      else if ($urandom_range(0, 1))
        rq.read_index = vis;
    end else if (pick < 80) begin
      rq = random_req(FN_TICK);
    end else if (pick < 83) begin
      rq = random_req(FN_CLEAR);
    end else if (pick < 93) begin
      rq = random_req(FN_RESTORE);
      if ($urandom_range(0, 1))
        rq.stored_write_index = SLOT_W'($urandom_range(0, 4094) * ENTRIES_PER_SECTOR);
      case ($urandom_range(0, 3))
        0: rq.stored_count = $urandom_range(0, 300);
        1: rq.stored_count = ENTRY_LIMIT - 70 + $urandom_range(0, 140);
        2: rq.stored_count = 32'hFFFF_FFFF - $urandom_range(0, 140);
        default: ;
      endcase
    end else begin
      rq = random_req(3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI)));
    end
    return rq;
  endfunction

  task automatic test_random_traffic();
    for (int i = 0; i < 150; i++) begin
      no_idle = ((i / 25) % 2) == 1;
      if (i == 60) write_flash_present(1'b0);
      if (i == 75) write_flash_present(1'b1);
      send_request(random_item());
    end
    no_idle = 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid === 1'b1) begin
      if (expected_ops.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no request outstanding, op %0d", $time, result.op);
      end else begin
        want_op = expected_ops.pop_front();
        report_field("op", 32'(want_op.op), 32'(result.op));
        report_field("flash_addr", 32'(want_op.flash_addr), 32'(result.flash_addr));
        report_field("stamp", want_op.stamp, result.stamp);
        report_field("out_type", 32'(want_op.out_type), 32'(result.out_type));
        report_field("out_len", 32'(want_op.out_len), 32'(result.out_len));
        report_field("saved_index", 32'(want_op.saved_index), 32'(result.saved_index));
        report_field("saved_count", want_op.saved_count, result.saved_count);
        report_field("saved_boots", want_op.saved_boots, result.saved_boots);
        report_field("visible_count", 32'(want_op.visible_count),
                     32'(result.visible_count));
        report_field("last", 32'(want_op.last), 32'(result.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** circular_flash_log_manager_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_in = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    no_idle = 1'b0;
    flash_on = 1'b0;
    slot_ptr = '0;
    entry_total = '0;
    boot_cnt = '0;
    ms_clock = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_flash_absent();
    write_flash_present(1'b1);
    test_log_writes();
    test_log_reads();
    test_restore_cases();
    test_wrapped_log();
    test_clear();
    test_random_traffic();

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_ops.size() == 0) begin
      $display("** circular_flash_log_manager_unit: PASSED **");
    end else begin
      $display("** circular_flash_log_manager_unit: FAILED **");
    end
    $finish;
  end

endmodule
